>>> design/tpc_pkg.sv
// Shared types and constants of the triangle plane clipper.
package tpc_pkg;

	localparam int FIX_W      = 32;              // Q16.16 coordinate
	localparam int SHADE_W    = 16;
	localparam int PROD_W     = 2 * FIX_W;       // Q32.32 product
	localparam int DIST_W     = 50;              // signed distance, never overflows
	localparam int DA_W       = DIST_W - 1;      // inside distance, known non-negative
	localparam int DEN_W      = DIST_W;          // d_a - d_b, unsigned
	localparam int DA_LO_W    = 25;              // low slice of d_a for the split multiply
	localparam int DA_HI_W    = DA_W - DA_LO_W;
	localparam int NUM_W      = FIX_W + DA_W;    // |delta| * d_a
	localparam int Q_W        = FIX_W;           // quotient is below |delta|
	localparam int DIV_STEPS  = 4;               // quotient bits per divider stage
	localparam int DIV_STAGES = Q_W / DIV_STEPS;
	localparam int PADDR_W    = 4;

	localparam logic [1:0] REG_NX  = 2'd0;
	localparam logic [1:0] REG_NY  = 2'd1;
	localparam logic [1:0] REG_NZ  = 2'd2;
	localparam logic [1:0] REG_OFF = 2'd3;

	localparam logic signed [FIX_W-1:0] NX_RST  = 32'sd0;
	localparam logic signed [FIX_W-1:0] NY_RST  = 32'sd0;
	localparam logic signed [FIX_W-1:0] NZ_RST  = 32'sd65536;
	localparam logic signed [FIX_W-1:0] OFF_RST = 32'sd0;

	// index 0 = x, 1 = y, 2 = z
	typedef logic [2:0][FIX_W-1:0] vtx_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_ONE,
		MODE_TWO,
		MODE_ALL
	} mode_t;

	// Data that rides alongside the intersection lanes.
	typedef struct packed {
		vtx_t                p0;
		vtx_t                p1;
		vtx_t                p2;
		vtx_t                a0;
		vtx_t                a1;
		logic [1:0][2:0]     neg;
		mode_t               mode;
		logic [SHADE_W-1:0]  shade;
	} side_t;

endpackage

>>> design/tpc_if.sv
// Triangle input and output channel interfaces.
interface tpc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] a_x;
	logic signed [31:0] a_y;
	logic signed [31:0] a_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] c_x;
	logic signed [31:0] c_y;
	logic signed [31:0] c_z;
	logic        [15:0] shade;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, shade,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, shade,
		output ready);
endinterface

interface tpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_a_x;
	logic signed [31:0] out_a_y;
	logic signed [31:0] out_a_z;
	logic signed [31:0] out_b_x;
	logic signed [31:0] out_b_y;
	logic signed [31:0] out_b_z;
	logic signed [31:0] out_c_x;
	logic signed [31:0] out_c_y;
	logic signed [31:0] out_c_z;
	logic        [15:0] out_shade;
	logic               last;

	modport source (output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, out_shade, last, input ready);
	modport sink (input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, out_shade, last, output ready);
endinterface

>>> design/triangle_plane_clipper.sv
// Clips triangles against one programmable plane; top level with APB registers.
// Throughput: one input per cycle while the output accepts and each input gives at most
//   one triangle; an input that splits into two holds the whole pipeline until both are taken.
// The depth is set by the 32-bit quotient, 4 bits per stage over 8 divider stages.
// Reset (arst_n low, asynchronous) empties the pipeline and loads normal (0,0,1.0), offset 0.
module triangle_plane_clipper import tpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	tpc_in_if.sink             tri_in,
	tpc_out_if.source          tri_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int VLD_N = 5 + DIV_STAGES;

	// ---------------- configuration registers ----------------
	logic signed [FIX_W-1:0] nrm_q [3];
	logic signed [FIX_W-1:0] off_q;
	logic [1:0]              reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q[0] <= NX_RST;
			nrm_q[1] <= NY_RST;
			nrm_q[2] <= NZ_RST;
			off_q    <= OFF_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_NX:  nrm_q[0] <= pwdata;
				REG_NY:  nrm_q[1] <= pwdata;
				REG_NZ:  nrm_q[2] <= pwdata;
				REG_OFF: off_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NX:  prdata = nrm_q[0];
			REG_NY:  prdata = nrm_q[1];
			REG_NZ:  prdata = nrm_q[2];
			REG_OFF: prdata = off_q;
			default: prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// Whole pipeline moves as one; it holds only while the output stage has a
	// triangle waiting or a second triangle still to send.
	logic             en;
	logic [VLD_N-1:0] vld;
	logic             ov_q;
	logic             ph_q;
	logic             last_o;

	assign en           = !ov_q || (tri_out.ready && last_o);
	assign tri_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[VLD_N-2:0], tri_in.valid};
		end
	end

	// ---------------- s1: nine products n_k * p_k ----------------
	vtx_t                     vin [3];
	vtx_t                     v_s1 [3];
	logic [SHADE_W-1:0]       shade_s1;
	logic signed [PROD_W-1:0] prod_s1 [3][3];

	assign vin[0] = {tri_in.a_z, tri_in.a_y, tri_in.a_x};
	assign vin[1] = {tri_in.b_z, tri_in.b_y, tri_in.b_x};
	assign vin[2] = {tri_in.c_z, tri_in.c_y, tri_in.c_x};

	always_ff @(posedge clk) begin
		if (en) begin
			shade_s1 <= tri_in.shade;
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= vin[i];
				for (int k = 0; k < 3; k++) begin
					prod_s1[i][k] <= PROD_W'(nrm_q[k]) * PROD_W'($signed(vin[i][k]));
				end
			end
		end
	end

	// ---------------- s2: signed distances ----------------
	vtx_t                     v_s2 [3];
	logic [SHADE_W-1:0]       shade_s2;
	logic signed [DIST_W-1:0] d_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			shade_s2 <= shade_s1;
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= v_s1[i];
				// arithmetic shift is the floor of product / 2^16
				d_s2[i] <= DIST_W'(prod_s1[i][0] >>> 16) + DIST_W'(prod_s1[i][1] >>> 16)
					+ DIST_W'(prod_s1[i][2] >>> 16) - DIST_W'(off_q);
			end
		end
	end

	// ---------------- s3: classify, pick edges, set up divides ----------------
	logic [2:0]  inb;
	mode_t       mode_n;
	logic [1:0]  ip0, ip1, ip2, ia0, ib0, ia1, ib1;
	side_t       side_n;
	logic [1:0]  ia [2];
	logic [1:0]  ib [2];
	logic signed [FIX_W:0] dlt;

	side_t            side_s3;
	logic [FIX_W-1:0] mag_s3 [2][3];
	logic [DA_W-1:0]  da_s3 [2];
	logic [DEN_W-1:0] den_s3 [2];
	logic [FIX_W-1:0] mag_n [2][3];
	logic [DA_W-1:0]  da_n [2];
	logic [DEN_W-1:0] den_n [2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inb[i] = !d_s2[i][DIST_W-1];
		end
		mode_n = MODE_NONE;
		ip0 = 2'd0; ip1 = 2'd1; ip2 = 2'd2;
		ia0 = 2'd0; ib0 = 2'd1; ia1 = 2'd0; ib1 = 2'd2;
		// inside/outside lists kept in vertex order
		case (inb)
			3'b111: mode_n = MODE_ALL;
			3'b001: begin mode_n = MODE_ONE; ip0 = 2'd0; ia0 = 2'd0; ib0 = 2'd1; ia1 = 2'd0; ib1 = 2'd2; end
			3'b010: begin mode_n = MODE_ONE; ip0 = 2'd1; ia0 = 2'd1; ib0 = 2'd0; ia1 = 2'd1; ib1 = 2'd2; end
			3'b100: begin mode_n = MODE_ONE; ip0 = 2'd2; ia0 = 2'd2; ib0 = 2'd0; ia1 = 2'd2; ib1 = 2'd1; end
			3'b011: begin
				mode_n = MODE_TWO; ip0 = 2'd0; ip1 = 2'd1;
				ia0 = 2'd0; ib0 = 2'd2; ia1 = 2'd1; ib1 = 2'd2;
			end
			3'b101: begin
				mode_n = MODE_TWO; ip0 = 2'd0; ip1 = 2'd2;
				ia0 = 2'd0; ib0 = 2'd1; ia1 = 2'd2; ib1 = 2'd1;
			end
			3'b110: begin
				mode_n = MODE_TWO; ip0 = 2'd1; ip1 = 2'd2;
				ia0 = 2'd1; ib0 = 2'd0; ia1 = 2'd2; ib1 = 2'd0;
			end
			default: mode_n = MODE_NONE;
		endcase
		ia[0] = ia0; ib[0] = ib0; ia[1] = ia1; ib[1] = ib1;

		side_n.p0    = v_s2[ip0];
		side_n.p1    = v_s2[ip1];
		side_n.p2    = v_s2[ip2];
		side_n.a0    = v_s2[ia0];
		side_n.a1    = v_s2[ia1];
		side_n.mode  = mode_n;
		side_n.shade = shade_s2;
		side_n.neg   = '0;
		dlt          = '0;
		for (int j = 0; j < 2; j++) begin
			// in a split d_a >= 0 > d_b, so the divisor is at least one
			den_n[j] = DEN_W'(d_s2[ia[j]] - d_s2[ib[j]]);
			da_n[j]  = d_s2[ia[j]][DA_W-1:0];
			for (int k = 0; k < 3; k++) begin
				dlt = (FIX_W+1)'($signed(v_s2[ib[j]][k])) - (FIX_W+1)'($signed(v_s2[ia[j]][k]));
				side_n.neg[j][k] = dlt[FIX_W];
				mag_n[j][k] = dlt[FIX_W] ? FIX_W'(-dlt) : dlt[FIX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_n;
			mag_s3  <= mag_n;
			da_s3   <= da_n;
			den_s3  <= den_n;
		end
	end

	// ---------------- s4: split multiply |delta| * d_a ----------------
	side_t                    side_s4;
	logic [DEN_W-1:0]         den_s4 [2];
	logic [FIX_W+DA_LO_W-1:0] plo_s4 [2][3];
	logic [FIX_W+DA_HI_W-1:0] phi_s4 [2][3];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			den_s4  <= den_s3;
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 3; k++) begin
					plo_s4[j][k] <= (FIX_W+DA_LO_W)'(mag_s3[j][k])
						* (FIX_W+DA_LO_W)'(da_s3[j][DA_LO_W-1:0]);
					phi_s4[j][k] <= (FIX_W+DA_HI_W)'(mag_s3[j][k])
						* (FIX_W+DA_HI_W)'(da_s3[j][DA_W-1:DA_LO_W]);
				end
			end
		end
	end

	// ---------------- s5: join partial products ----------------
	side_t            side_s5;
	logic [DEN_W-1:0] den_s5 [2];
	logic [NUM_W-1:0] num_s5 [2][3];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			den_s5  <= den_s4;
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 3; k++) begin
					num_s5[j][k] <= NUM_W'(plo_s4[j][k]) + (NUM_W'(phi_s4[j][k]) << DA_LO_W);
				end
			end
		end
	end

	// ---------------- divider lanes and matching side delay line ----------------
	logic [Q_W-1:0] quo [2][3];
	side_t          side_dl [DIV_STAGES];

	for (genvar j = 0; j < 2; j++) begin : g_edge
		for (genvar k = 0; k < 3; k++) begin : g_comp
			tpc_div u_div (
				.clk (clk),
				.en  (en),
				.num (num_s5[j][k]),
				.den (den_s5[j]),
				.quo (quo[j][k])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[0] <= side_s5;
			for (int s = 1; s < DIV_STAGES; s++) begin
				side_dl[s] <= side_dl[s-1];
			end
		end
	end

	// ---------------- output stage ----------------
	side_t o_q;
	vtx_t  x0_q, x1_q;
	side_t dl_last;
	logic  take;

	assign dl_last = side_dl[DIV_STAGES-1];
	assign take    = tri_out.valid && tri_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			ph_q <= 1'b0;
		end else if (en) begin
			// a fully clipped triangle is dropped here
			ov_q <= vld[VLD_N-1] && (dl_last.mode != MODE_NONE);
			ph_q <= 1'b0;
		end else if (take) begin
			ph_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_q <= dl_last;
			for (int k = 0; k < 3; k++) begin
				x0_q[k] <= dl_last.a0[k] + (dl_last.neg[0][k] ? -quo[0][k] : quo[0][k]);
				x1_q[k] <= dl_last.a1[k] + (dl_last.neg[1][k] ? -quo[1][k] : quo[1][k]);
			end
		end
	end

	vtx_t oa, ob, oc;

	always_comb begin
		oa     = o_q.p0;
		ob     = o_q.p1;
		oc     = o_q.p2;
		last_o = 1'b1;
		case (o_q.mode)
			MODE_ONE: begin
				ob = x0_q;
				oc = x1_q;
			end
			MODE_TWO: begin
				if (!ph_q) begin
					oc     = x0_q;
					last_o = 1'b0;
				end else begin
					oa = o_q.p1;
					ob = x0_q;
					oc = x1_q;
				end
			end
			default: ;
		endcase
	end

	assign tri_out.valid     = ov_q;
	assign tri_out.out_a_x   = oa[0];
	assign tri_out.out_a_y   = oa[1];
	assign tri_out.out_a_z   = oa[2];
	assign tri_out.out_b_x   = ob[0];
	assign tri_out.out_b_y   = ob[1];
	assign tri_out.out_b_z   = ob[2];
	assign tri_out.out_c_x   = oc[0];
	assign tri_out.out_c_y   = oc[1];
	assign tri_out.out_c_z   = oc[2];
	assign tri_out.out_shade = o_q.shade;
	assign tri_out.last      = last_o;

	// ---------------- assertions ----------------
	a_ph_two: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |-> ov_q && (o_q.mode == MODE_TWO))
		else $error("second-triangle phase outside a two-triangle split");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !tri_out.ready |=> $stable(vld))
		else $error("pipeline moved while result held");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		tri_out.valid && !tri_out.last |-> (o_q.mode == MODE_TWO) && !ph_q)
		else $error("non-final triangle outside first half of split");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> o_q.mode != MODE_NONE)
		else $error("fully clipped triangle reached output");

	a_split_next: assert property (@(posedge clk) disable iff (!arst_n)
		take && !tri_out.last |=> ov_q && ph_q)
		else $error("second triangle of split lost");

endmodule

>>> design/tpc_div.sv
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
module tpc_div import tpc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [Q_W-1:0]   low_s [DIV_STAGES];
	logic [Q_W-1:0]   quo_s [DIV_STAGES];

	// one compare-subtract step: returns {new remainder, quotient bit}
	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
		input logic [DEN_W-1:0] dv, input logic nb);
		logic [DEN_W:0] r2;
		logic [DEN_W:0] dif;
		r2  = {rem, nb};
		dif = r2 - {1'b0, dv};
		if (r2 >= {1'b0, dv}) begin
			return {dif[DEN_W-1:0], 1'b1};
		end
		return {r2[DEN_W-1:0], 1'b0};
	endfunction

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [Q_W-1:0]   low_i;
		logic [Q_W-1:0]   quo_i;
		logic [DEN_W-1:0] rem_n;
		logic [Q_W-1:0]   low_n;
		logic [Q_W-1:0]   quo_n;
		logic [DEN_W:0]   st;

		if (g == 0) begin : g_first
			// top bits of the numerator are already below the divisor
			assign rem_i = DEN_W'(num[NUM_W-1:Q_W]);
			assign den_i = den;
			assign low_i = num[Q_W-1:0];
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[g-1];
			assign den_i = den_s[g-1];
			assign low_i = low_s[g-1];
			assign quo_i = quo_s[g-1];
		end

		always_comb begin
			rem_n = rem_i;
			low_n = low_i;
			quo_n = quo_i;
			st    = '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				st    = div_step(rem_n, den_i, low_n[Q_W-1]);
				rem_n = st[DEN_W:1];
				low_n = {low_n[Q_W-2:0], 1'b0};
				quo_n = {quo_n[Q_W-2:0], st[0]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_n;
				den_s[g] <= den_i;
				low_s[g] <= low_n;
				quo_s[g] <= quo_n;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule
